### design/aes_pkg.sv
`default_nettype none

package aes_pkg;

  typedef logic [127:0] blk_t;

  typedef enum logic [1:0] {
    CFG_KEY_LOW  = 2'd0,
    CFG_KEY_HIGH = 2'd1
  } cfg_idx_e;

  localparam int unsigned NumRounds = 10;

  localparam logic [7:0] RCON [NumRounds] = '{
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
  };

  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52, 8'h09, 8'h6a, 8'hd5, 8'h30, 8'h36, 8'ha5, 8'h38,
    8'hbf, 8'h40, 8'ha3, 8'h9e, 8'h81, 8'hf3, 8'hd7, 8'hfb,
    8'h7c, 8'he3, 8'h39, 8'h82, 8'h9b, 8'h2f, 8'hff, 8'h87,
    8'h34, 8'h8e, 8'h43, 8'h44, 8'hc4, 8'hde, 8'he9, 8'hcb,
    8'h54, 8'h7b, 8'h94, 8'h32, 8'ha6, 8'hc2, 8'h23, 8'h3d,
    8'hee, 8'h4c, 8'h95, 8'h0b, 8'h42, 8'hfa, 8'hc3, 8'h4e,
    8'h08, 8'h2e, 8'ha1, 8'h66, 8'h28, 8'hd9, 8'h24, 8'hb2,
    8'h76, 8'h5b, 8'ha2, 8'h49, 8'h6d, 8'h8b, 8'hd1, 8'h25,
    8'h72, 8'hf8, 8'hf6, 8'h64, 8'h86, 8'h68, 8'h98, 8'h16,
    8'hd4, 8'ha4, 8'h5c, 8'hcc, 8'h5d, 8'h65, 8'hb6, 8'h92,
    8'h6c, 8'h70, 8'h48, 8'h50, 8'hfd, 8'hed, 8'hb9, 8'hda,
    8'h5e, 8'h15, 8'h46, 8'h57, 8'ha7, 8'h8d, 8'h9d, 8'h84,
    8'h90, 8'hd8, 8'hab, 8'h00, 8'h8c, 8'hbc, 8'hd3, 8'h0a,
    8'hf7, 8'he4, 8'h58, 8'h05, 8'hb8, 8'hb3, 8'h45, 8'h06,
    8'hd0, 8'h2c, 8'h1e, 8'h8f, 8'hca, 8'h3f, 8'h0f, 8'h02,
    8'hc1, 8'haf, 8'hbd, 8'h03, 8'h01, 8'h13, 8'h8a, 8'h6b,
    8'h3a, 8'h91, 8'h11, 8'h41, 8'h4f, 8'h67, 8'hdc, 8'hea,
    8'h97, 8'hf2, 8'hcf, 8'hce, 8'hf0, 8'hb4, 8'he6, 8'h73,
    8'h96, 8'hac, 8'h74, 8'h22, 8'he7, 8'had, 8'h35, 8'h85,
    8'he2, 8'hf9, 8'h37, 8'he8, 8'h1c, 8'h75, 8'hdf, 8'h6e,
    8'h47, 8'hf1, 8'h1a, 8'h71, 8'h1d, 8'h29, 8'hc5, 8'h89,
    8'h6f, 8'hb7, 8'h62, 8'h0e, 8'haa, 8'h18, 8'hbe, 8'h1b,
    8'hfc, 8'h56, 8'h3e, 8'h4b, 8'hc6, 8'hd2, 8'h79, 8'h20,
    8'h9a, 8'hdb, 8'hc0, 8'hfe, 8'h78, 8'hcd, 8'h5a, 8'hf4,
    8'h1f, 8'hdd, 8'ha8, 8'h33, 8'h88, 8'h07, 8'hc7, 8'h31,
    8'hb1, 8'h12, 8'h10, 8'h59, 8'h27, 8'h80, 8'hec, 8'h5f,
    8'h60, 8'h51, 8'h7f, 8'ha9, 8'h19, 8'hb5, 8'h4a, 8'h0d,
    8'h2d, 8'he5, 8'h7a, 8'h9f, 8'h93, 8'hc9, 8'h9c, 8'hef,
    8'ha0, 8'he0, 8'h3b, 8'h4d, 8'hae, 8'h2a, 8'hf5, 8'hb0,
    8'hc8, 8'heb, 8'hbb, 8'h3c, 8'h83, 8'h53, 8'h99, 8'h61,
    8'h17, 8'h2b, 8'h04, 8'h7e, 8'hba, 8'h77, 8'hd6, 8'h26,
    8'he1, 8'h69, 8'h14, 8'h63, 8'h55, 8'h21, 8'h0c, 8'h7d
  };

endpackage

`default_nettype wire

### design/aes_round.sv
`default_nettype none

// One AES round (forward or inverse) together with one step of the key
// schedule, forward while encrypting and backward while decrypting.
module aes_round (
  input  var aes_pkg::blk_t st_i,
  input  var aes_pkg::blk_t rk_i,
  input  var logic [7:0]    rcon_i,
  input  var logic          decrypt_i,
  input  var logic          last_i,
  output aes_pkg::blk_t     st_o,
  output aes_pkg::blk_t     rk_o
);

  function automatic logic [7:0] xt(input logic [7:0] a);
    xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  aes_pkg::blk_t fwd_key, inv_key, sub_f, sub_i, mix_f, mix_i, t_d;

  // Forward key step: derive round key r from round key r-1.
  always_comb begin
    logic [31:0] t;
    t = {aes_pkg::SBOX[rk_i[103:96]], aes_pkg::SBOX[rk_i[127:120]],
         aes_pkg::SBOX[rk_i[119:112]], aes_pkg::SBOX[rk_i[111:104]] ^ rcon_i};
    fwd_key[31:0]   = rk_i[31:0] ^ t;
    fwd_key[63:32]  = rk_i[63:32] ^ fwd_key[31:0];
    fwd_key[95:64]  = rk_i[95:64] ^ fwd_key[63:32];
    fwd_key[127:96] = rk_i[127:96] ^ fwd_key[95:64];
  end

  // Backward key step: recover round key r-1 from round key r.
  always_comb begin
    logic [31:0] p3;
    logic [31:0] t;
    p3 = rk_i[127:96] ^ rk_i[95:64];
    t = {aes_pkg::SBOX[p3[7:0]], aes_pkg::SBOX[p3[31:24]],
         aes_pkg::SBOX[p3[23:16]], aes_pkg::SBOX[p3[15:8]] ^ rcon_i};
    inv_key[127:96] = p3;
    inv_key[95:64]  = rk_i[95:64] ^ rk_i[63:32];
    inv_key[63:32]  = rk_i[63:32] ^ rk_i[31:0];
    inv_key[31:0]   = rk_i[31:0] ^ t;
  end

  // Byte substitution with row shift; byte i sits in row i%4, column i/4.
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        sub_f[8*(r+4*c) +: 8] = aes_pkg::SBOX[st_i[8*(r+4*((c+r)%4)) +: 8]];
        sub_i[8*(r+4*c) +: 8] = aes_pkg::INV_SBOX[st_i[8*(r+4*((c+4-r)%4)) +: 8]];
      end
    end
  end

  assign t_d = sub_i ^ inv_key;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      logic [7:0] a0, a1, a2, a3;
      logic [7:0] b0, b1, b2, b3;
      logic [7:0] m9 [4];
      logic [7:0] m11 [4];
      logic [7:0] m13 [4];
      logic [7:0] m14 [4];
      logic [7:0] x2, x4, x8;
      a0 = sub_f[32*c +: 8];
      a1 = sub_f[32*c+8 +: 8];
      a2 = sub_f[32*c+16 +: 8];
      a3 = sub_f[32*c+24 +: 8];
      mix_f[32*c +: 8]    = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
      mix_f[32*c+8 +: 8]  = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
      mix_f[32*c+16 +: 8] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
      mix_f[32*c+24 +: 8] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
      for (int k = 0; k < 4; k++) begin
        b0 = t_d[32*c+8*k +: 8];
        x2 = xt(b0);
        x4 = xt(x2);
        x8 = xt(x4);
        m9[k]  = x8 ^ b0;
        m11[k] = x8 ^ x2 ^ b0;
        m13[k] = x8 ^ x4 ^ b0;
        m14[k] = x8 ^ x4 ^ x2;
      end
      b0 = m14[0] ^ m11[1] ^ m13[2] ^ m9[3];
      b1 = m9[0] ^ m14[1] ^ m11[2] ^ m13[3];
      b2 = m13[0] ^ m9[1] ^ m14[2] ^ m11[3];
      b3 = m11[0] ^ m13[1] ^ m9[2] ^ m14[3];
      mix_i[32*c +: 32] = {b3, b2, b1, b0};
    end
  end

  always_comb begin
    if (decrypt_i) begin
      rk_o = inv_key;
      st_o = last_i ? t_d : mix_i;
    end else begin
      rk_o = fwd_key;
      st_o = (last_i ? sub_f : mix_f) ^ fwd_key;
    end
  end

endmodule

`default_nettype wire

### design/aes128_block_cipher.sv
`default_nettype none

// Channel  | Signals                                          | Direction
// ---------+--------------------------------------------------+----------
// command  | start_i, busy_o, action_i, block_low_i/high_i    | in
// result   | out_valid_o, out_low_o, out_high_o               | out
// config   | cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i| in
//
// An item goes from acceptance straight to ST_ROUND when the key schedule
// is current: one shared round unit runs one AES round per cycle.
// After a key write the first item first walks the schedule forward to the
// last round key in ST_EXPAND and adds a load step in ST_INIT.
// Reset clears the key registers to zero and marks the schedule stale.
// The result is shown for one cycle only; the receiver cannot stall it.
module aes128_block_cipher (
  input  var logic        clk_i,
  input  var logic        rst_ni,
  input  var logic        start_i,
  output logic            busy_o,
  input  var logic        action_i,
  input  var logic [63:0] block_low_i,
  input  var logic [63:0] block_high_i,
  output logic            out_valid_o,
  output logic [63:0]     out_low_o,
  output logic [63:0]     out_high_o,
  input  var logic        cfg_valid_i,
  output logic            cfg_ready_o,
  input  var logic [1:0]  cfg_index_i,
  input  var logic [63:0] cfg_data_i
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXPAND,
    ST_INIT,
    ST_ROUND
  } state_e;

  state_e        state_q;
  logic          act_q;
  logic          ready_q;
  logic [3:0]    cnt_q;
  logic [63:0]   key_lo_q, key_hi_q;
  aes_pkg::blk_t key10_q, st_q, rk_q, out_q;
  logic          out_valid_q;

  aes_pkg::blk_t key0, blk_in, st_nx, rk_nx, sel_key;
  logic [3:0]    rc_idx;
  logic          dec, last, accept, cfg_wr;

  assign key0    = {key_hi_q, key_lo_q};
  assign blk_in  = {block_high_i, block_low_i};
  assign busy_o  = (state_q != ST_IDLE);
  assign accept  = start_i && !busy_o;
  assign cfg_ready_o = !busy_o;
  assign cfg_wr  = cfg_valid_i && cfg_ready_o;

  // Decryption walks the key schedule backward from the last round key.
  assign dec     = (state_q == ST_ROUND) && act_q;
  assign last    = (cnt_q == 4'(aes_pkg::NumRounds));
  assign rc_idx  = dec ? (4'(aes_pkg::NumRounds) - cnt_q) : (cnt_q - 4'd1);
  assign sel_key = act_q ? key10_q : key0;

  aes_round u_round (
    .st_i      (st_q),
    .rk_i      (rk_q),
    .rcon_i    (aes_pkg::RCON[rc_idx]),
    .decrypt_i (dec),
    .last_i    (last),
    .st_o      (st_nx),
    .rk_o      (rk_nx)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      act_q       <= 1'b0;
      ready_q     <= 1'b0;
      cnt_q       <= 4'd1;
      key_lo_q    <= '0;
      key_hi_q    <= '0;
      key10_q     <= '0;
      st_q        <= '0;
      rk_q        <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (cfg_wr) begin
            case (cfg_index_i)
              aes_pkg::CFG_KEY_LOW: begin
                key_lo_q <= cfg_data_i;
                ready_q  <= 1'b0;
              end
              aes_pkg::CFG_KEY_HIGH: begin
                key_hi_q <= cfg_data_i;
                ready_q  <= 1'b0;
              end
              default: begin
              end
            endcase
          end
          if (accept) begin
            act_q <= action_i;
            cnt_q <= 4'd1;
            if (ready_q) begin
              st_q    <= blk_in ^ (action_i ? key10_q : key0);
              rk_q    <= action_i ? key10_q : key0;
              state_q <= ST_ROUND;
            end else begin
              st_q    <= blk_in;
              rk_q    <= key0;
              state_q <= ST_EXPAND;
            end
          end
        end
        ST_EXPAND: begin
          rk_q <= rk_nx;
          if (last) begin
            key10_q <= rk_nx;
            ready_q <= 1'b1;
            state_q <= ST_INIT;
          end else begin
            cnt_q <= cnt_q + 4'd1;
          end
        end
        ST_INIT: begin
          st_q    <= st_q ^ sel_key;
          rk_q    <= sel_key;
          cnt_q   <= 4'd1;
          state_q <= ST_ROUND;
        end
        ST_ROUND: begin
          st_q <= st_nx;
          rk_q <= rk_nx;
          if (last) begin
            out_q       <= st_nx;
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end else begin
            cnt_q <= cnt_q + 4'd1;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_low_o   = out_q[63:0];
  assign out_high_o  = out_q[127:64];

  a_result_after_round: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ($past(state_q) == ST_ROUND && $past(last)))
    else $error("result strobe without a final round");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_o)
    else $error("item accepted but block not busy");

  a_key_write_stale: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_wr && (cfg_index_i == aes_pkg::CFG_KEY_LOW ||
                cfg_index_i == aes_pkg::CFG_KEY_HIGH)) |=> !ready_q)
    else $error("key write did not mark schedule stale");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROUND || state_q == ST_EXPAND) |->
      (cnt_q >= 4'd1 && cnt_q <= 4'(aes_pkg::NumRounds)))
    else $error("round count out of range");

endmodule

`default_nettype wire

### verif/tb_aes128_block_cipher.sv
`timescale 1ns / 1ps

module tb_aes128_block_cipher;

  // Register indexes that the block ignores.
  localparam logic [1:0] CfgSpareA = 2'd2;
  localparam logic [1:0] CfgSpareB = 2'd3;
  localparam bit ActEncrypt = 1'b0;
  localparam bit ActDecrypt = 1'b1;
  localparam int unsigned IdleLimit = 3000;
  localparam int unsigned DrainCycles = 30;

  typedef struct packed {
    bit          dec;
    logic [63:0] lo;
    logic [63:0] hi;
  } block_item_t;

  typedef struct packed {
    logic [63:0] lo;
    logic [63:0] hi;
  } cipher_out_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic        action_i = 1'b0;
  logic [63:0] block_low_i = '0;
  logic [63:0] block_high_i = '0;
  logic        out_valid_o;
  logic [63:0] out_low_o;
  logic [63:0] out_high_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = aes_pkg::CFG_KEY_LOW;
  logic [63:0] cfg_data_i = '0;

  aes128_block_cipher dut (.*);

  always #5 clk_i = ~clk_i;

  block_item_t pending_blocks[$];
  cipher_out_t expected_blocks[$];
  bit          failed = 1'b0;
  bit          taken = 1'b0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned idle_cycles = 0;

  // Shadow of the key registers and the expanded schedule.
  logic [63:0] key_lo_q = '0;
  logic [63:0] key_hi_q = '0;
  logic [7:0]  fwd_sub[256];
  logic [7:0]  rev_sub[256];
  logic [7:0]  round_keys[11][16];

  function automatic logic [7:0] gf_times(logic [7:0] a, logic [7:0] b);
    logic [7:0] r;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) r ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return r;
  endfunction

  function automatic logic [7:0] rotl8(logic [7:0] b, int n);
    return (b << n) | (b >> (8 - n));
  endfunction

  // The S-box is rebuilt from field inversion and the affine map, so the
  // predictor does not lean on the tables the design uses.
  function automatic void build_sub_tables();
    logic [7:0] inv, p, aff;
    for (int a = 0; a < 256; a++) begin
      inv = 8'h01;
      p = a[7:0];
      for (int e = 0; e < 8; e++) begin
        if (e != 0) inv = gf_times(inv, p);
        p = gf_times(p, p);
      end
      aff = inv ^ rotl8(inv, 1) ^ rotl8(inv, 2) ^ rotl8(inv, 3) ^ rotl8(inv, 4) ^ 8'h63;
      fwd_sub[a] = aff;
      rev_sub[aff] = a[7:0];
    end
  endfunction

  function automatic void expand_key();
    logic [7:0] rcon, t0;
    rcon = 8'h01;
    for (int i = 0; i < 8; i++) begin
      round_keys[0][i] = key_lo_q[8*i +: 8];
      round_keys[0][8+i] = key_hi_q[8*i +: 8];
    end
    for (int r = 1; r <= 10; r++) begin
      for (int i = 0; i < 4; i++) begin
        t0 = fwd_sub[round_keys[r-1][12 + ((i + 1) % 4)]];
        if (i == 0) t0 ^= rcon;
        round_keys[r][i] = round_keys[r-1][i] ^ t0;
      end
      for (int i = 4; i < 16; i++) round_keys[r][i] = round_keys[r-1][i] ^ round_keys[r][i-4];
      rcon = gf_times(rcon, 8'h02);
    end
  endfunction

  function automatic logic [31:0] mix_word(logic [31:0] w, bit inverse);
    logic [7:0] a[4];
    logic [7:0] m[4];
    logic [31:0] r;
    for (int i = 0; i < 4; i++) a[i] = w[8*i +: 8];
    if (inverse) begin
      m = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
    end else begin
      m = '{8'h02, 8'h03, 8'h01, 8'h01};
    end
    for (int row = 0; row < 4; row++) begin
      r[8*row +: 8] = '0;
      for (int k = 0; k < 4; k++) r[8*row +: 8] ^= gf_times(a[k], m[(k - row + 4) % 4]);
    end
    return r;
  endfunction

  // Standard cipher for encryption and the textbook inverse cipher for
  // decryption; the block's inverse rounds follow the same step order.
  function automatic cipher_out_t cipher_block(block_item_t it);
    logic [7:0]  st[16];
    logic [7:0]  tmp[16];
    logic [31:0] col;
    cipher_out_t res;
    int rk;
    for (int i = 0; i < 8; i++) begin
      st[i] = it.lo[8*i +: 8];
      st[8+i] = it.hi[8*i +: 8];
    end
    rk = it.dec ? 10 : 0;
    for (int i = 0; i < 16; i++) st[i] ^= round_keys[rk][i];
    for (int rnd = 1; rnd <= 10; rnd++) begin
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 4; c++) begin
          if (it.dec) tmp[r + 4*c] = rev_sub[st[r + 4*((c - r + 4) % 4)]];
          else tmp[r + 4*c] = fwd_sub[st[r + 4*((c + r) % 4)]];
        end
      end
      st = tmp;
      rk = it.dec ? 10 - rnd : rnd;
      if (!it.dec && rnd != 10) begin
        for (int c = 0; c < 4; c++) begin
          col = mix_word({st[4*c+3], st[4*c+2], st[4*c+1], st[4*c]}, 1'b0);
          for (int i = 0; i < 4; i++) st[4*c+i] = col[8*i +: 8];
        end
      end
      for (int i = 0; i < 16; i++) st[i] ^= round_keys[rk][i];
      if (it.dec && rnd != 10) begin
        for (int c = 0; c < 4; c++) begin
          col = mix_word({st[4*c+3], st[4*c+2], st[4*c+1], st[4*c]}, 1'b1);
          for (int i = 0; i < 4; i++) st[4*c+i] = col[8*i +: 8];
        end
      end
    end
    for (int i = 0; i < 8; i++) begin
      res.lo[8*i +: 8] = st[i];
      res.hi[8*i +: 8] = st[8+i];
    end
    return res;
  endfunction

  // Driver: bursts of items separated by random gaps, changes at falling edges.
  always @(negedge clk_i) begin
    if (start_i && !taken) begin
      // The current item waits until the block takes it.
    end else if (gap_left != 0 || pending_blocks.size() == 0) begin
      if (gap_left != 0) gap_left--;
      start_i <= 1'b0;
    end else begin
      block_item_t it;
      it = pending_blocks.pop_front();
      action_i <= it.dec;
      block_low_i <= it.lo;
      block_high_i <= it.hi;
      start_i <= 1'b1;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      if (burst_left == 0) gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
    end
    taken = 1'b0;
  end

  // Monitor: predicts on each accepted item and checks each result strobe.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      cipher_out_t want;
      bit moved;
      moved = cfg_valid_i && cfg_ready_o;
      if (start_i && !busy_o) begin
        taken = 1'b1;
        moved = 1'b1;
        expected_blocks.push_back(cipher_block('{action_i, block_low_i, block_high_i}));
      end
      if (out_valid_o) begin
        moved = 1'b1;
        if (expected_blocks.size() == 0) begin
          $error("result with no item outstanding: %h %h", out_high_o, out_low_o);
          failed = 1'b1;
        end else begin
          want = expected_blocks.pop_front();
          if (out_low_o !== want.lo) begin
            $error("out_low: expected %h, actual %h", want.lo, out_low_o);
            failed = 1'b1;
          end
          if (out_high_o !== want.hi) begin
            $error("out_high: expected %h, actual %h", want.hi, out_high_o);
            failed = 1'b1;
          end
        end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [63:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == aes_pkg::CFG_KEY_LOW) key_lo_q = data;
    else if (idx == aes_pkg::CFG_KEY_HIGH) key_hi_q = data;
    expand_key();
  endtask

  // Waits until the block has delivered everything, then lets it settle.
  task automatic drain();
    do @(posedge clk_i);
    while (pending_blocks.size() != 0 || start_i || expected_blocks.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Mostly random blocks; some decrypt a known ciphertext to round-trip.
  task automatic queue_random(int n);
    block_item_t it;
    cipher_out_t ct;
    for (int k = 0; k < n; k++) begin
      it = '{bit'($urandom_range(0, 1)), rand64(), rand64()};
      case ($urandom_range(0, 7))
        0: it.lo = '0;
        1: it.hi = '1;
        2: begin
          ct = cipher_block('{ActEncrypt, it.lo, it.hi});
          it = '{ActDecrypt, ct.lo, ct.hi};
        end
        default: ;
      endcase
      pending_blocks.push_back(it);
    end
  endtask

  initial begin
    build_sub_tables();
    expand_key();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset key of zero, with no write first: the schedule is built stale.
    pending_blocks.push_back('{ActEncrypt, 64'h0, 64'h0});
    pending_blocks.push_back('{ActDecrypt, 64'h0, 64'h0});
    pending_blocks.push_back('{ActEncrypt, '1, '1});
    pending_blocks.push_back('{ActDecrypt, '1, '1});
    drain();

    // Standard key 00..0f with the standard plaintext 00112233..ff.
    write_reg(aes_pkg::CFG_KEY_LOW, 64'h0706050403020100);
    write_reg(aes_pkg::CFG_KEY_HIGH, 64'h0f0e0d0c0b0a0908);
    pending_blocks.push_back('{ActEncrypt, 64'h7766554433221100, 64'hffeeddccbbaa9988});
    pending_blocks.push_back('{ActDecrypt, 64'hd8e0c469_30047b6a, 64'h5ac5b470_80b7cdd8});
    pending_blocks.push_back('{ActEncrypt, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555});
    pending_blocks.push_back('{ActDecrypt, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa});
    pending_blocks.push_back('{ActEncrypt, 64'h0000000000000001, 64'h8000000000000000});
    pending_blocks.push_back('{ActDecrypt, 64'h8000000000000000, 64'h0000000000000001});
    queue_random(60);
    drain();

    // Writes to the spare indexes must leave the key alone.
    write_reg(CfgSpareA, '1);
    write_reg(CfgSpareB, 64'h0123456789abcdef);
    pending_blocks.push_back('{ActEncrypt, 64'h7766554433221100, 64'hffeeddccbbaa9988});
    queue_random(30);
    drain();

    // All-ones key.
    write_reg(aes_pkg::CFG_KEY_LOW, '1);
    write_reg(aes_pkg::CFG_KEY_HIGH, '1);
    pending_blocks.push_back('{ActEncrypt, '0, '0});
    pending_blocks.push_back('{ActDecrypt, '1, '1});
    queue_random(60);
    drain();

    // Only the high half changes.
    write_reg(aes_pkg::CFG_KEY_HIGH, '0);
    queue_random(50);
    drain();

    // Back to an all-zero key through explicit writes.
    write_reg(aes_pkg::CFG_KEY_LOW, '0);
    write_reg(aes_pkg::CFG_KEY_HIGH, '0);
    queue_random(50);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      if (ph % 3 != 2) write_reg(aes_pkg::CFG_KEY_LOW, rand64());
      if (ph % 3 != 1) write_reg(aes_pkg::CFG_KEY_HIGH, rand64());
      queue_random(50);
      drain();
    end

    if (!failed) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### aes128_block_cipher.f
design/aes_pkg.sv
design/aes_round.sv
design/aes128_block_cipher.sv
verif/tb_aes128_block_cipher.sv
